@@ rtl/core/abkf_pkg.sv @@
// Shared types, constants and saturation helpers for the angle/bias Kalman filter.
`timescale 1ns / 1ps

package abkf_pkg;

    localparam int unsigned ANG_W   = 32;  // Q16.16 angle, rate, bias
    localparam int unsigned DT_W    = 24;  // Q0.24 time step
    localparam int unsigned COV_W   = 40;  // Q8.32 covariance and noise
    localparam int unsigned GAIN_W  = 32;  // Q8.24 gain
    localparam int unsigned OPA_W   = 44;  // multiplier wide operand
    localparam int unsigned OPB_W   = 32;  // multiplier narrow operand
    localparam int unsigned MRES_W  = 52;  // rounded product
    localparam int unsigned SUM_W   = 54;  // accumulate before saturation
    localparam int unsigned DEN_W   = 42;  // R + P00, signed

    localparam logic [1:0] REG_ANGLE_Q = 2'd0;
    localparam logic [1:0] REG_BIAS_Q  = 2'd1;
    localparam logic [1:0] REG_MEAS_R  = 2'd2;

    localparam logic [COV_W-1:0] ANGLE_Q_RST = 40'd4294967;
    localparam logic [COV_W-1:0] BIAS_Q_RST  = 40'd4294967;
    localparam logic [COV_W-1:0] MEAS_R_RST  = 40'd2147483648;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        STEP_PRED,
        STEP_P00,
        STEP_P01,
        STEP_P11,
        STEP_K0,
        STEP_K1,
        STEP_C0,
        STEP_C1,
        STEP_C2,
        STEP_C3,
        STEP_ANG,
        STEP_BIAS
    } step_t;

    function automatic logic signed [ANG_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = 54'sd2147483647;
        lo = -54'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[ANG_W-1:0];
        end
    endfunction

    function automatic logic signed [COV_W-1:0] sat40(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = 54'sd549755813887;
        lo = -54'sd549755813888;
        if (v > hi) begin
            sat40 = 40'sh7F_FFFF_FFFF;
        end else if (v < lo) begin
            sat40 = 40'sh80_0000_0000;
        end else begin
            sat40 = v[COV_W-1:0];
        end
    endfunction

endpackage

@@ rtl/core/angle_bias_kalman_filter_core.sv @@
// Top level of the two-state angle and gyro-bias Kalman filter.
`timescale 1ns / 1ps

// Two-state Kalman filter tracking an angle and the gyro bias. Each input beat
// (measured angle, gyro rate, time step) predicts the angle and covariance,
// forms both gains by dividing by R + P00, corrects angle and bias and shrinks
// the covariance; one result beat (angle, bias estimate, Q16.16, saturated)
// follows. A small sequencer runs twelve steps through one shared multiplier
// (10 products) and one serial divider (2 gains); a gain with zero or
// negative denominator, or one that saturates up front, skips the divider's
// iteration. One item is in flight at a time; a finished result waits in an
// output register, so the next beat is accepted while it is unclaimed. The
// user must write the noise registers through cfg_wr_en / cfg_index /
// cfg_wr_data only while idle; the block does not enforce this. Index 3 is
// ignored. State resets to zero.

module angle_bias_kalman_filter_core
    import abkf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [COV_W-1:0]         cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [ANG_W-1:0]  s_angle_measured,
    input  logic signed [ANG_W-1:0]  s_gyro_rate,
    input  logic [DT_W-1:0]          s_time_step,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ANG_W-1:0]  m_angle_estimate,
    output logic signed [ANG_W-1:0]  m_bias_estimate
);

    // noise registers
    logic [COV_W-1:0]         qa_reg;
    logic [COV_W-1:0]         qb_reg;
    logic [COV_W-1:0]         r_reg;

    // filter state
    logic signed [ANG_W-1:0]  ang_reg;
    logic signed [ANG_W-1:0]  bias_reg;
    logic signed [COV_W-1:0]  cov_reg [4];

    // per-item working values
    logic signed [ANG_W-1:0]  z_reg;
    logic signed [ANG_W-1:0]  rate_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [ANG_W-1:0]  pred_reg;
    logic signed [COV_W-1:0]  pw_reg [4];
    logic signed [GAIN_W-1:0] k0_reg;
    logic signed [GAIN_W-1:0] k1_reg;

    logic                     m_valid_reg;
    logic signed [ANG_W-1:0]  out_ang_reg;
    logic signed [ANG_W-1:0]  out_bias_reg;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    logic                     is_div;
    logic                     mul_start;
    logic                     div_start;
    logic                     mul_done;
    logic                     div_done;
    logic                     unit_done;
    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [MRES_W-1:0] mres;
    logic signed [SUM_W-1:0]  m54;
    logic signed [GAIN_W-1:0] kq;
    logic signed [COV_W-1:0]  div_num;
    logic signed [DEN_W-1:0]  den;
    logic signed [OPA_W-1:0]  resid;
    logic [OPB_W-1:0]         dt_b;
    logic                     accept;
    logic                     out_load;

    assign accept = s_valid && s_ready;
    assign dt_b   = {8'd0, dt_reg};
    assign resid  = {{12{z_reg[31]}}, z_reg} - {{12{pred_reg[31]}}, pred_reg};
    assign m54    = {{2{mres[MRES_W-1]}}, mres};
    assign den    = $signed({2'b00, r_reg}) + {{2{pw_reg[0][39]}}, pw_reg[0]};
    assign div_num = (step_reg == STEP_K0) ? pw_reg[0] : pw_reg[2];
    assign is_div  = (step_reg == STEP_K0) || (step_reg == STEP_K1);

    // operand selection for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (step_reg)
            STEP_PRED: begin
                op_a = {{12{rate_reg[31]}}, rate_reg} - {{12{bias_reg[31]}}, bias_reg};
                op_b = dt_b;
            end
            STEP_P00: begin
                op_a = $signed({4'd0, qa_reg}) - {{4{cov_reg[1][39]}}, cov_reg[1]}
                       - {{4{cov_reg[2][39]}}, cov_reg[2]};
                op_b = dt_b;
            end
            STEP_P01: begin
                op_a = {{4{cov_reg[3][39]}}, cov_reg[3]};
                op_b = dt_b;
            end
            STEP_P11: begin
                op_a = $signed({4'd0, qb_reg});
                op_b = dt_b;
            end
            STEP_C0: begin
                op_a = {{4{pw_reg[0][39]}}, pw_reg[0]};
                op_b = k0_reg;
            end
            STEP_C1: begin
                op_a = {{4{pw_reg[1][39]}}, pw_reg[1]};
                op_b = k0_reg;
            end
            STEP_C2: begin
                op_a = {{4{pw_reg[0][39]}}, pw_reg[0]};
                op_b = k1_reg;
            end
            STEP_C3: begin
                op_a = {{4{pw_reg[1][39]}}, pw_reg[1]};
                op_b = k1_reg;
            end
            STEP_ANG: begin
                op_a = resid;
                op_b = k0_reg;
            end
            STEP_BIAS: begin
                op_a = resid;
                op_b = k1_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    abkf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mul_done),
        .result  (mres)
    );

    abkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den),
        .done    (div_done),
        .quot    (kq)
    );

    assign unit_done = mul_done || div_done;

    // sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ISSUE;
                    step_next  = STEP_PRED;
                end
            end
            ST_ISSUE: begin
                mul_start  = !is_div;
                div_start  = is_div;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (unit_done) begin
                    if (step_reg == STEP_BIAS) begin
                        state_next = ST_DONE;
                    end else begin
                        step_next  = step_t'(step_reg + 4'd1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_PRED;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // configuration, state and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_reg      <= ANGLE_Q_RST;
            qb_reg      <= BIAS_Q_RST;
            r_reg       <= MEAS_R_RST;
            ang_reg     <= '0;
            bias_reg    <= '0;
            cov_reg[0]  <= '0;
            cov_reg[1]  <= '0;
            cov_reg[2]  <= '0;
            cov_reg[3]  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_ANGLE_Q: qa_reg <= cfg_wr_data;
                    REG_BIAS_Q:  qb_reg <= cfg_wr_data;
                    REG_MEAS_R:  r_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_WAIT && unit_done) begin
                unique case (step_reg)
                    STEP_C0:   cov_reg[0] <= sat40({{14{pw_reg[0][39]}}, pw_reg[0]} - m54);
                    STEP_C1:   cov_reg[1] <= sat40({{14{pw_reg[1][39]}}, pw_reg[1]} - m54);
                    STEP_C2:   cov_reg[2] <= sat40({{14{pw_reg[2][39]}}, pw_reg[2]} - m54);
                    STEP_C3:   cov_reg[3] <= sat40({{14{pw_reg[3][39]}}, pw_reg[3]} - m54);
                    STEP_ANG:  ang_reg  <= sat32({{22{pred_reg[31]}}, pred_reg} + m54);
                    STEP_BIAS: bias_reg <= sat32({{22{bias_reg[31]}}, bias_reg} + m54);
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            z_reg    <= s_angle_measured;
            rate_reg <= s_gyro_rate;
            dt_reg   <= s_time_step;
        end
        if (state_reg == ST_WAIT && unit_done) begin
            unique case (step_reg)
                STEP_PRED: pred_reg  <= sat32({{22{ang_reg[31]}}, ang_reg} + m54);
                STEP_P00:  pw_reg[0] <= sat40({{14{cov_reg[0][39]}}, cov_reg[0]} + m54);
                STEP_P01: begin
                    pw_reg[1] <= sat40({{14{cov_reg[1][39]}}, cov_reg[1]} - m54);
                    pw_reg[2] <= sat40({{14{cov_reg[2][39]}}, cov_reg[2]} - m54);
                end
                STEP_P11:  pw_reg[3] <= sat40({{14{cov_reg[3][39]}}, cov_reg[3]} + m54);
                STEP_K0:   k0_reg <= kq;
                STEP_K1:   k1_reg <= kq;
                default: ;
            endcase
        end
        if (out_load) begin
            out_ang_reg  <= ang_reg;
            out_bias_reg <= bias_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_angle_estimate = out_ang_reg;
    assign m_bias_estimate  = out_bias_reg;

    // the two shared units never finish together
    assert property (@(posedge aclk) disable iff (!aresetn) !(mul_done && div_done))
        else $error("multiplier and divider finished in the same cycle");

    // the divider only answers during the gain steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (step_reg == STEP_K0 || step_reg == STEP_K1))
        else $error("divider result outside a gain step");

    // an accepted beat starts the sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_ISSUE && step_reg == STEP_PRED))
        else $error("accepted beat did not start the sequence");

endmodule

@@ rtl/core/abkf_mul.sv @@
// Shared multiplier: 44x32 signed product in two 23x32 halves, rounded >> 24.
`timescale 1ns / 1ps

module abkf_mul
    import abkf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [OPA_W-1:0]  op_a,
    input  logic signed [OPB_W-1:0]  op_b,
    output logic                     done,
    output logic signed [MRES_W-1:0] result
);

    logic signed [OPA_W-1:0]  a_reg;
    logic signed [OPB_W-1:0]  b_reg;
    logic [1:0]               ph_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [54:0]       prod_reg;
    logic signed [75:0]       acc_reg;
    logic signed [MRES_W-1:0] res_reg;
    logic signed [22:0]       half;
    logic signed [54:0]       prod;
    logic signed [75:0]       acc_rnd;

    // low half unsigned, high half signed
    assign half    = (ph_reg == 2'd0) ? $signed({1'b0, a_reg[21:0]})
                                      : $signed({a_reg[43], a_reg[43:22]});
    assign prod    = half * b_reg;
    assign acc_rnd = acc_reg + 76'sd8388608;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= op_a;
                b_reg    <= op_b;
                ph_reg   <= 2'd0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                ph_reg <= ph_reg + 2'd1;
                case (ph_reg)
                    2'd0: prod_reg <= prod;
                    2'd1: begin
                        acc_reg  <= {{21{prod_reg[54]}}, prod_reg};
                        prod_reg <= prod;
                    end
                    2'd2: acc_reg <= acc_reg + ({{21{prod_reg[54]}}, prod_reg} <<< 22);
                    default: begin
                        res_reg  <= acc_rnd[75:24];
                        done_reg <= 1'b1;
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ rtl/core/abkf_div.sv @@
// Serial gain divider: (p << 24) / e, truncated toward zero, saturated to 32 bits.
`timescale 1ns / 1ps

module abkf_div
    import abkf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [COV_W-1:0]  num,
    input  logic signed [DEN_W-1:0]  den,
    output logic                     done,
    output logic signed [GAIN_W-1:0] quot
);

    logic [COV_W-1:0]         mag;
    logic [49:0]              den_x512;
    logic                     ovf;
    logic [40:0]              den_reg;
    logic [40:0]              rem_reg;
    logic [32:0]              shf_reg;
    logic [32:0]              q_reg;
    logic [5:0]               cnt_reg;
    logic                     neg_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [GAIN_W-1:0] quot_reg;
    logic [41:0]              trial;
    logic [41:0]              diff;
    logic signed [33:0]       q_signed;

    assign mag      = num[COV_W-1] ? COV_W'(-num) : COV_W'(num);
    // quotient would reach 2^33: saturate without iterating
    assign den_x512 = {den[40:0], 9'd0};
    assign ovf      = {10'd0, mag} >= den_x512;
    assign trial    = {rem_reg, shf_reg[32]};
    assign diff     = trial - {1'b0, den_reg};
    assign q_signed = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                neg_reg <= num[COV_W-1];
                den_reg <= den[40:0];
                if (den <= 0) begin
                    quot_reg <= '0;
                    done_reg <= 1'b1;
                end else if (ovf) begin
                    quot_reg <= num[COV_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= {10'd0, mag[39:9]};
                    shf_reg  <= {mag[8:0], 24'd0};
                    q_reg    <= '0;
                    cnt_reg  <= 6'd33;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (cnt_reg != 6'd0) begin
                    if (trial >= {1'b0, den_reg}) begin
                        rem_reg <= diff[40:0];
                        q_reg   <= {q_reg[31:0], 1'b1};
                    end else begin
                        rem_reg <= trial[40:0];
                        q_reg   <= {q_reg[31:0], 1'b0};
                    end
                    shf_reg <= {shf_reg[31:0], 1'b0};
                    cnt_reg <= cnt_reg - 6'd1;
                end else begin
                    if (!neg_reg && (q_reg > 33'd2147483647)) begin
                        quot_reg <= 32'sh7FFF_FFFF;
                    end else if (neg_reg && (q_reg > 33'd2147483648)) begin
                        quot_reg <= 32'sh8000_0000;
                    end else begin
                        quot_reg <= q_signed[GAIN_W-1:0];
                    end
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
